// ===== sv/rsi_pkg.sv =====
// rsi_pkg: shared widths, register indexes and beat/stage structs for the
// ray/sphere intersection pipeline. No dependencies.
package rsi_pkg;

    localparam int MAX_HITS = 16;

    localparam int LW = 34;   // centre minus origin
    localparam int BW = 36;   // projected distance b
    localparam int DW = 72;   // squared terms and discriminant
    localparam int RW = 36;   // root, one pipeline stage per bit

    localparam logic [2:0] CFG_CENTER_X     = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y     = 3'd1;
    localparam logic [2:0] CFG_CENTER_Z     = 3'd2;
    localparam logic [2:0] CFG_END_CENTER_X = 3'd3;
    localparam logic [2:0] CFG_END_CENTER_Y = 3'd4;
    localparam logic [2:0] CFG_END_CENTER_Z = 3'd5;
    localparam logic [2:0] CFG_RADIUS       = 3'd6;

    localparam logic [16:0] TIME_ONE = 17'd65536;
    localparam logic [30:0] T_MAX    = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [17:0] dir_x;
        logic signed [17:0] dir_y;
        logic signed [17:0] dir_z;
        logic [16:0]        shutter_time;
        logic               blur_on;
        logic [4:0]         hit_index;
    } ray_t;

    typedef struct packed {
        logic [2:0][31:0] c0;
        logic [2:0][31:0] c1;
        logic [30:0]      radius;
    } cfg_t;

    typedef struct packed {
        logic signed [BW-1:0] b;
        logic [DW-1:0]        delta;
        logic                 hit;
        logic [4:0]           idx;
    } geo_t;

    typedef struct packed {
        logic signed [BW-1:0] b;
        logic [DW-1:0]        rem;
        logic [RW-1:0]        q;
        logic                 hit;
        logic [4:0]           idx;
    } sq_t;

    typedef struct packed {
        logic [30:0] far_t;
        logic        far_kept;
        logic [30:0] near_t;
        logic        near_kept;
        logic [4:0]  next_index;
    } hit_t;

endpackage

// ===== sv/rsi_ray_if.sv =====
// rsi_ray_if: input channel carrying one ray per beat.
// Depends on nothing.
interface rsi_ray_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] dir_z;
    logic [16:0]        shutter_time;
    logic               blur_on;
    logic [4:0]         hit_index;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    shutter_time, blur_on, hit_index, input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  shutter_time, blur_on, hit_index, output ready);
endinterface

// ===== sv/rsi_hit_if.sv =====
// rsi_hit_if: output channel carrying one intersection result per beat.
// Depends on nothing.
interface rsi_hit_if;
    logic        valid;
    logic        ready;
    logic [30:0] far_t;
    logic        far_kept;
    logic [30:0] near_t;
    logic        near_kept;
    logic [4:0]  next_index;

    modport source (output valid, far_t, far_kept, near_t, near_kept, next_index,
                    input ready);
    modport sink (input valid, far_t, far_kept, near_t, near_kept, next_index,
                  output ready);
endinterface

// ===== sv/rsi_geom.sv =====
// rsi_geom: six-stage front end: blur offset, L, products, b and |L|^2,
// b^2 partials, discriminant. Depends on rsi_pkg.
module rsi_geom
(
    input  logic                clk,
    input  logic                rst_n,
    input  rsi_pkg::cfg_t       cfg,
    input  logic                vld_in,
    input  rsi_pkg::ray_t       ray,
    output logic                en_up,
    input  logic                en_dn,
    output logic                vld_out,
    output rsi_pkg::geo_t       geo
);

    logic [5:0] v_reg;
    logic [5:0] v_next;
    logic [5:0] en;

    // stage 1
    logic signed [50:0] s1_prod_reg [3];
    logic signed [50:0] s1_prod_next [3];
    logic signed [31:0] s1_org_reg [3];
    logic signed [31:0] s1_org_next [3];
    logic signed [17:0] s1_dir_reg [3];
    logic signed [17:0] s1_dir_next [3];
    logic [4:0]         s1_idx_reg;
    // stage 2
    logic signed [rsi_pkg::LW-1:0] s2_l_reg [3];
    logic signed [rsi_pkg::LW-1:0] s2_l_next [3];
    logic signed [17:0]            s2_dir_reg [3];
    logic [4:0]                    s2_idx_reg;
    // stage 3
    logic signed [51:0] s3_pl_reg [3];
    logic signed [51:0] s3_pl_next [3];
    logic [63:0]        s3_sq_reg [3];
    logic [63:0]        s3_sq_next [3];
    logic [4:0]         s3_idx_reg;
    // stage 4
    logic signed [rsi_pkg::BW-1:0] s4_b_reg;
    logic signed [rsi_pkg::BW-1:0] s4_b_next;
    logic [65:0]                   s4_lsq_reg;
    logic [65:0]                   s4_lsq_next;
    logic [61:0]                   s4_r2_reg;
    logic [61:0]                   s4_r2_next;
    logic [4:0]                    s4_idx_reg;
    // stage 5
    logic signed [rsi_pkg::BW-1:0] s5_b_reg;
    logic [35:0]                   s5_hh_reg;
    logic [35:0]                   s5_hh_next;
    logic [35:0]                   s5_hl_reg;
    logic [35:0]                   s5_hl_next;
    logic [35:0]                   s5_ll_reg;
    logic [35:0]                   s5_ll_next;
    logic [65:0]                   s5_lsq_reg;
    logic [61:0]                   s5_r2_reg;
    logic [4:0]                    s5_idx_reg;
    // stage 6
    rsi_pkg::geo_t s6_reg;
    rsi_pkg::geo_t s6_next;

    always_comb
    begin
        en[5] = !v_reg[5] || en_dn;
        for (int k = 4; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k + 1];
        end
        v_next[0] = vld_in;
        for (int k = 1; k < 6; k++)
        begin
            v_next[k] = v_reg[k - 1];
        end
    end

    assign en_up = en[0];

    // stage 1: (c1 - c0) * time when blur is on, else zero; time saturates at one
    always_comb
    begin
        logic [16:0]        tsat;
        logic signed [32:0] diff;
        tsat = (ray.shutter_time > rsi_pkg::TIME_ONE) ? rsi_pkg::TIME_ONE
                                                       : ray.shutter_time;
        s1_org_next[0] = ray.origin_x;
        s1_org_next[1] = ray.origin_y;
        s1_org_next[2] = ray.origin_z;
        s1_dir_next[0] = ray.dir_x;
        s1_dir_next[1] = ray.dir_y;
        s1_dir_next[2] = ray.dir_z;
        for (int i = 0; i < 3; i++)
        begin
            diff = $signed({cfg.c1[i][31], cfg.c1[i]}) - $signed({cfg.c0[i][31], cfg.c0[i]});
            s1_prod_next[i] = ray.blur_on ? 51'(diff * $signed({1'b0, tsat})) : '0;
        end
    end

    // stage 2: L = centre - origin
    always_comb
    begin
        logic signed [50:0] off;
        logic signed [35:0] c;
        logic signed [35:0] l36;
        for (int i = 0; i < 3; i++)
        begin
            off = s1_prod_reg[i] >>> 16;
            c   = $signed({{4{cfg.c0[i][31]}}, cfg.c0[i]}) + $signed(off[35:0]);
            l36 = c - $signed({{4{s1_org_reg[i][31]}}, s1_org_reg[i]});
            s2_l_next[i] = l36[rsi_pkg::LW-1:0];
        end
    end

    // stage 3: L.dir terms and |L_i|^2
    always_comb
    begin
        logic [rsi_pkg::LW-1:0] ml;
        for (int i = 0; i < 3; i++)
        begin
            s3_pl_next[i] = 52'(s2_l_reg[i] * s2_dir_reg[i]);
            ml = s2_l_reg[i][rsi_pkg::LW-1] ? rsi_pkg::LW'(-s2_l_reg[i])
                                              : rsi_pkg::LW'(s2_l_reg[i]);
            s3_sq_next[i] = ml[31:0] * ml[31:0];
        end
    end

    // stage 4: b, |L|^2, r^2
    always_comb
    begin
        logic signed [53:0] dsum;
        logic signed [53:0] bs;
        dsum = 54'(s3_pl_reg[0]) + 54'(s3_pl_reg[1]) + 54'(s3_pl_reg[2]);
        bs   = dsum >>> 16;
        s4_b_next   = bs[rsi_pkg::BW-1:0];
        s4_lsq_next = 66'(s3_sq_reg[0]) + 66'(s3_sq_reg[1]) + 66'(s3_sq_reg[2]);
        s4_r2_next  = cfg.radius * cfg.radius;
    end

    // stage 5: b^2 partial products, 18-bit halves
    always_comb
    begin
        logic [rsi_pkg::BW-1:0] mb;
        mb = s4_b_reg[rsi_pkg::BW-1] ? rsi_pkg::BW'(-s4_b_reg) : rsi_pkg::BW'(s4_b_reg);
        s5_hh_next = mb[35:18] * mb[35:18];
        s5_hl_next = mb[35:18] * mb[17:0];
        s5_ll_next = mb[17:0] * mb[17:0];
    end

    // stage 6: delta = b^2 + r^2 - |L|^2
    always_comb
    begin
        logic [rsi_pkg::DW-1:0] bb;
        logic [rsi_pkg::DW-1:0] lhs;
        bb  = (rsi_pkg::DW'(s5_hh_reg) << 36) + (rsi_pkg::DW'(s5_hl_reg) << 19)
            + rsi_pkg::DW'(s5_ll_reg);
        lhs = bb + rsi_pkg::DW'(s5_r2_reg);
        s6_next.b     = s5_b_reg;
        s6_next.hit   = lhs > rsi_pkg::DW'(s5_lsq_reg);
        s6_next.delta = lhs - rsi_pkg::DW'(s5_lsq_reg);
        s6_next.idx   = s5_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < 6; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_prod_reg <= s1_prod_next;
            s1_org_reg  <= s1_org_next;
            s1_dir_reg  <= s1_dir_next;
            s1_idx_reg  <= ray.hit_index;
        end
        if (en[1])
        begin
            s2_l_reg   <= s2_l_next;
            s2_dir_reg <= s1_dir_reg;
            s2_idx_reg <= s1_idx_reg;
        end
        if (en[2])
        begin
            s3_pl_reg  <= s3_pl_next;
            s3_sq_reg  <= s3_sq_next;
            s3_idx_reg <= s2_idx_reg;
        end
        if (en[3])
        begin
            s4_b_reg   <= s4_b_next;
            s4_lsq_reg <= s4_lsq_next;
            s4_r2_reg  <= s4_r2_next;
            s4_idx_reg <= s3_idx_reg;
        end
        if (en[4])
        begin
            s5_b_reg   <= s4_b_reg;
            s5_hh_reg  <= s5_hh_next;
            s5_hl_reg  <= s5_hl_next;
            s5_ll_reg  <= s5_ll_next;
            s5_lsq_reg <= s4_lsq_reg;
            s5_r2_reg  <= s4_r2_reg;
            s5_idx_reg <= s4_idx_reg;
        end
        if (en[5])
        begin
            s6_reg <= s6_next;
        end
    end

    assign vld_out = v_reg[5];
    assign geo     = s6_reg;

endmodule

// ===== sv/rsi_sqrt.sv =====
// rsi_sqrt: pipelined restoring square root, one root bit per stage.
// Depends on rsi_pkg.
module rsi_sqrt
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vld_in,
    input  rsi_pkg::geo_t       geo,
    output logic                en_up,
    input  logic                en_dn,
    output logic                vld_out,
    output rsi_pkg::sq_t        res
);

    localparam int N = rsi_pkg::RW;

    logic [N-1:0]  v_reg;
    logic [N-1:0]  en;
    rsi_pkg::sq_t  st_reg  [N];
    rsi_pkg::sq_t  st_next [N];
    rsi_pkg::sq_t  first;

    always_comb
    begin
        en[N-1] = !v_reg[N-1] || en_dn;
        for (int k = N - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k + 1];
        end
    end

    assign en_up = en[0];

    always_comb
    begin
        first.b   = geo.b;
        first.rem = geo.delta;
        first.q   = '0;
        first.hit = geo.hit;
        first.idx = geo.idx;
    end

    for (genvar j = 0; j < N; j++)
    begin : g_bit
        localparam int K = N - 1 - j;
        rsi_pkg::sq_t cur;
        logic [rsi_pkg::DW-1:0] trial;

        if (j == 0)
        begin : g_head
            assign cur = first;
        end
        else
        begin : g_body
            assign cur = st_reg[j - 1];
        end

        // (q + 2^K)^2 - q^2 = q*2^(K+1) + 2^(2K)
        always_comb
        begin
            trial = (rsi_pkg::DW'(cur.q) << (K + 1)) | (rsi_pkg::DW'(1) << (2 * K));
            st_next[j] = cur;
            if (cur.rem >= trial)
            begin
                st_next[j].rem  = cur.rem - trial;
                st_next[j].q[K] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en[j])
            begin
                v_reg[j] <= (j == 0) ? vld_in : v_reg[(j == 0) ? 0 : j - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                st_reg[j] <= st_next[j];
            end
        end
    end

    assign vld_out = v_reg[N-1];
    assign res     = st_reg[N-1];

endmodule

// ===== sv/rsi_out.sv =====
// rsi_out: output stage: distances, hit-slot bookkeeping, saturation and
// the output register. Depends on rsi_pkg.
module rsi_out
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vld_in,
    input  rsi_pkg::sq_t        sq,
    output logic                en_up,
    input  logic                ready,
    output logic                vld_out,
    output rsi_pkg::hit_t       hit
);

    logic          v_reg;
    rsi_pkg::hit_t h_reg;
    rsi_pkg::hit_t h_next;

    assign en_up = !v_reg || ready;

    always_comb
    begin
        logic signed [rsi_pkg::BW+1:0] tf;
        logic signed [rsi_pkg::BW+1:0] tn;
        logic [4:0]                    idx1;
        tf = $signed({{2{sq.b[rsi_pkg::BW-1]}}, sq.b}) + $signed({2'b00, sq.q});
        tn = $signed({{2{sq.b[rsi_pkg::BW-1]}}, sq.b}) - $signed({2'b00, sq.q});
        h_next.far_kept = sq.hit && (int'(sq.idx) < rsi_pkg::MAX_HITS) && !tf[rsi_pkg::BW+1];
        idx1 = sq.idx + 5'(h_next.far_kept);
        h_next.near_kept = sq.hit && (int'(idx1) < rsi_pkg::MAX_HITS) && !tn[rsi_pkg::BW+1];
        h_next.next_index = idx1 + 5'(h_next.near_kept);
        h_next.far_t = '0;
        h_next.near_t = '0;
        if (h_next.far_kept)
        begin
            h_next.far_t = (tf > $signed({7'd0, rsi_pkg::T_MAX})) ? rsi_pkg::T_MAX : tf[30:0];
        end
        if (h_next.near_kept)
        begin
            h_next.near_t = (tn > $signed({7'd0, rsi_pkg::T_MAX})) ? rsi_pkg::T_MAX : tn[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en_up)
        begin
            v_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_up)
        begin
            h_reg <= h_next;
        end
    end

    assign vld_out = v_reg;
    assign hit     = h_reg;

endmodule

// ===== sv/ray_sphere_intersect_core.sv =====
// ray_sphere_intersect_core: fixed-point ray/sphere test, top level.
// Depends on rsi_pkg, rsi_ray_if, rsi_hit_if, rsi_geom, rsi_sqrt, rsi_out.
//
// Usage:
//   rays: one ray per beat (origin, unit direction, shutter time, blur flag,
//   current hit count). hits: exactly one result per ray, in ray order.
//   Sphere centre, end centre and radius are written through cfg_we /
//   cfg_index / cfg_data while the pipeline is empty; index 7 is ignored.
//   From ray beat to result a ray passes 6 front-end stages (centre, L,
//   products, b and |L|^2, b^2 partials, discriminant), 36 root stages at
//   one bit each, and the output register.
//   Throughput is one ray per cycle while hits.ready stays high; each stage holds one ray.
//   When hits.ready is low the pipeline closes up from the output: empty
//   stages keep filling, so rays.ready only drops once every stage is full.
//   Nothing is lost or repeated across a stall.
//   Reset clears all stage valid bits, sets both centres to zero and the
//   radius to 1.0.
module ray_sphere_intersect_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    rsi_ray_if.sink     rays,
    rsi_hit_if.source   hits
);

    rsi_pkg::cfg_t cfg_reg;
    rsi_pkg::ray_t ray;
    rsi_pkg::geo_t geo;
    rsi_pkg::sq_t  sq;
    rsi_pkg::hit_t hit;
    logic          geo_vld;
    logic          sq_vld;
    logic          sqrt_en;
    logic          out_en;
    logic          geom_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.c0     <= '0;
            cfg_reg.c1     <= '0;
            cfg_reg.radius <= 31'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rsi_pkg::CFG_CENTER_X:     cfg_reg.c0[0]  <= cfg_data;
                rsi_pkg::CFG_CENTER_Y:     cfg_reg.c0[1]  <= cfg_data;
                rsi_pkg::CFG_CENTER_Z:     cfg_reg.c0[2]  <= cfg_data;
                rsi_pkg::CFG_END_CENTER_X: cfg_reg.c1[0]  <= cfg_data;
                rsi_pkg::CFG_END_CENTER_Y: cfg_reg.c1[1]  <= cfg_data;
                rsi_pkg::CFG_END_CENTER_Z: cfg_reg.c1[2]  <= cfg_data;
                rsi_pkg::CFG_RADIUS:       cfg_reg.radius <= cfg_data[30:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        ray.origin_x     = rays.origin_x;
        ray.origin_y     = rays.origin_y;
        ray.origin_z     = rays.origin_z;
        ray.dir_x        = rays.dir_x;
        ray.dir_y        = rays.dir_y;
        ray.dir_z        = rays.dir_z;
        ray.shutter_time = rays.shutter_time;
        ray.blur_on      = rays.blur_on;
        ray.hit_index    = rays.hit_index;
    end

    rsi_geom u_geom
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .vld_in  (rays.valid),
        .ray     (ray),
        .en_up   (geom_en),
        .en_dn   (sqrt_en),
        .vld_out (geo_vld),
        .geo     (geo)
    );

    rsi_sqrt u_sqrt
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (geo_vld),
        .geo     (geo),
        .en_up   (sqrt_en),
        .en_dn   (out_en),
        .vld_out (sq_vld),
        .res     (sq)
    );

    rsi_out u_out
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (sq_vld),
        .sq      (sq),
        .en_up   (out_en),
        .ready   (hits.ready),
        .vld_out (hits.valid),
        .hit     (hit)
    );

    assign rays.ready      = geom_en;
    assign hits.far_t      = hit.far_t;
    assign hits.far_kept   = hit.far_kept;
    assign hits.near_t     = hit.near_t;
    assign hits.near_kept  = hit.near_kept;
    assign hits.next_index = hit.next_index;

    // near distance never beats far into a slot
    a_near_after_far: assert property (@(posedge clk) disable iff (!rst_n)
        hits.valid && hits.near_kept |-> hits.far_kept)
        else $error("near kept without far");

    a_unkept_zero: assert property (@(posedge clk) disable iff (!rst_n)
        hits.valid && (!hits.far_kept || !hits.near_kept)
        |-> (hits.far_kept || hits.far_t == '0) && (hits.near_kept || hits.near_t == '0))
        else $error("unrecorded distance not zero");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        hits.valid && (hits.far_kept || hits.near_kept)
        |-> int'(hits.next_index) <= rsi_pkg::MAX_HITS)
        else $error("hit count past limit");

    // an empty output register always opens the whole pipe
    a_open_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !hits.valid |-> rays.ready)
        else $error("input blocked with output empty");

endmodule

// ===== test/ray_sphere_intersect_core_tb.sv =====
// Self-checking testbench for ray_sphere_intersect_core: directed and random rays against
// an in-bench fixed-point predictor, random stalls on both channels.
// Depends on rsi_pkg, rsi_ray_if, rsi_hit_if and the core RTL.
`timescale 1ns / 1ps

module ray_sphere_intersect_core_tb;

    localparam int LATENCY   = 43;
    localparam int MAX_CYCLE = 600000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    rsi_ray_if rays ();
    rsi_hit_if hits ();

    ray_sphere_intersect_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rays      (rays),
        .hits      (hits)
    );

    // predictor copy of the sphere registers
    logic signed [31:0] sph_c0 [3];
    logic signed [31:0] sph_c1 [3];
    logic [30:0]        sph_r;

    rsi_pkg::hit_t hit_queue [$];
    int     mismatches;
    int     cycle;
    bit     hold_off;
    int     hold_cycles;
    logic   err_flag;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE)
        begin
            $display("ray_sphere_intersect_core: mismatch");
            $finish;
        end
    end

    function automatic logic [63:0] isqrt(input logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  cand;
        r = '0;
        for (int bitn = 63; bitn >= 0; bitn--)
        begin
            cand = r | (64'd1 << bitn);
            if ({64'd0, cand} * {64'd0, cand} <= v)
                r = cand;
        end
        return r;
    endfunction

    function automatic rsi_pkg::hit_t predict_hit(input rsi_pkg::ray_t ray);
        rsi_pkg::hit_t      h;
        logic signed [63:0] lv [3];
        logic signed [63:0] dsum;
        logic signed [63:0] b;
        logic signed [63:0] cen;
        logic signed [63:0] root;
        logic signed [63:0] tf;
        logic signed [63:0] tn;
        logic [127:0]       lhs;
        logic [127:0]       rhs;
        logic [63:0]        bm;
        logic [63:0]        lm;
        logic [16:0]        tm;
        logic [4:0]         idx;
        logic signed [17:0] dv [3];
        logic signed [31:0] ov [3];
        h    = '0;
        tm   = (ray.shutter_time > rsi_pkg::TIME_ONE) ? rsi_pkg::TIME_ONE : ray.shutter_time;
        idx  = ray.hit_index;
        dv   = '{ray.dir_x, ray.dir_y, ray.dir_z};
        ov   = '{ray.origin_x, ray.origin_y, ray.origin_z};
        dsum = 0;
        rhs  = '0;
        for (int i = 0; i < 3; i++)
        begin
            cen = sph_c0[i];
            if (ray.blur_on)
                cen = cen + (((64'(sph_c1[i]) - 64'(sph_c0[i])) * $signed({47'd0, tm})) >>> 16);
            lv[i] = cen - 64'(ov[i]);
            dsum  = dsum + lv[i] * 64'(dv[i]);
            lm    = lv[i] < 0 ? 64'(-lv[i]) : 64'(lv[i]);
            rhs   = rhs + {64'd0, lm} * {64'd0, lm};
        end
        b   = dsum >>> 16;
        bm  = b < 0 ? 64'(-b) : 64'(b);
        lhs = {64'd0, bm} * {64'd0, bm} + {97'd0, sph_r} * {97'd0, sph_r};
        if (lhs > rhs)
        begin
            root = $signed(isqrt(lhs - rhs));
            tf   = b + root;
            tn   = b - root;
            if (idx < rsi_pkg::MAX_HITS && tf >= 0)
            begin
                h.far_kept = 1'b1;
                h.far_t    = tf > 64'sh7FFF_FFFF ? rsi_pkg::T_MAX : tf[30:0];
                idx++;
            end
            if (idx < rsi_pkg::MAX_HITS && tn >= 0)
            begin
                h.near_kept = 1'b1;
                h.near_t    = tn > 64'sh7FFF_FFFF ? rsi_pkg::T_MAX : tn[30:0];
                idx++;
            end
        end
        h.next_index = idx;
        return h;
    endfunction

    // result side: random stalls, or a long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hits.ready <= 1'b0;
        else if (hold_off)
            hits.ready <= 1'b0;
        else
            hits.ready <= ($urandom_range(0, 9) < 7) ||
                          ($urandom_range(0, 3) == 0 && cycle[9]);
    end

    always @(posedge clk)
    begin
        if (hold_off)
            hold_cycles <= hold_cycles + 1;
    end

    // beat checker
    always @(posedge clk)
    begin
        rsi_pkg::hit_t got;
        rsi_pkg::hit_t want;
        if (rst_n && hits.valid && hits.ready)
        begin
            got = '{hits.far_t, hits.far_kept, hits.near_t, hits.near_kept, hits.next_index};
            if (hit_queue.size() == 0)
            begin
                err_flag = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected hit beat %p", got);
            end
            else
            begin
                want = hit_queue.pop_front();
                if (got !== want)
                begin
                    err_flag = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("hit beat: expected %p got %p", want, got);
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx <= rsi_pkg::CFG_CENTER_Z)
            sph_c0[idx[1:0]] = val;
        else if (idx <= rsi_pkg::CFG_END_CENTER_Z)
            sph_c1[2'(idx - rsi_pkg::CFG_END_CENTER_X)] = val;
        else if (idx == rsi_pkg::CFG_RADIUS)
            sph_r = val[30:0];
    endtask

    task automatic set_sphere(input logic [31:0] cx, cy, cz, ex, ey, ez, r);
        write_reg(rsi_pkg::CFG_CENTER_X, cx);
        write_reg(rsi_pkg::CFG_CENTER_Y, cy);
        write_reg(rsi_pkg::CFG_CENTER_Z, cz);
        write_reg(rsi_pkg::CFG_END_CENTER_X, ex);
        write_reg(rsi_pkg::CFG_END_CENTER_Y, ey);
        write_reg(rsi_pkg::CFG_END_CENTER_Z, ez);
        write_reg(rsi_pkg::CFG_RADIUS, r);
    endtask

    task automatic drain();
        while (hit_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // one ray beat; gap of random length first unless told not to
    task automatic send_ray(input rsi_pkg::ray_t ray, input bit no_gap = 1'b0);
        int gap;
        gap = 0;
        if (!no_gap)
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) :
                  ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        if (gap != 0)
        begin
            rays.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rays.valid        <= 1'b1;
        rays.origin_x     <= ray.origin_x;
        rays.origin_y     <= ray.origin_y;
        rays.origin_z     <= ray.origin_z;
        rays.dir_x        <= ray.dir_x;
        rays.dir_y        <= ray.dir_y;
        rays.dir_z        <= ray.dir_z;
        rays.shutter_time <= ray.shutter_time;
        rays.blur_on      <= ray.blur_on;
        rays.hit_index    <= ray.hit_index;
        @(posedge clk);
        while (!rays.ready)
            @(posedge clk);
        hit_queue.push_back(predict_hit(ray));
    endtask

    task automatic idle_input();
        rays.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [17:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return 18'sd65536;
            1: return -18'sd65536;
            2: return 18'($urandom);
            default: return 18'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic rsi_pkg::ray_t rand_ray(input bit aimed);
        rsi_pkg::ray_t r;
        r.origin_x     = aimed ? 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21))
                               : $urandom;
        r.origin_y     = aimed ? 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21))
                               : $urandom;
        r.origin_z     = aimed ? 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21))
                               : $urandom;
        r.dir_x        = rand_dir();
        r.dir_y        = rand_dir();
        r.dir_z        = rand_dir();
        r.shutter_time = ($urandom_range(0, 7) == 0) ? 17'($urandom) :
                         17'($urandom_range(0, 65536));
        r.blur_on      = $urandom_range(0, 1);
        r.hit_index    = ($urandom_range(0, 7) == 0) ? 5'($urandom) :
                         5'($urandom_range(0, 16));
        return r;
    endfunction

    // aim the ray at the start centre so that hits are common
    function automatic rsi_pkg::ray_t aimed_ray();
        rsi_pkg::ray_t r;
        r = rand_ray(1'b1);
        r.origin_x = sph_c0[0] - 32'(r.dir_x) * 8;
        r.origin_y = sph_c0[1] - 32'(r.dir_y) * 8;
        r.origin_z = sph_c0[2] - 32'(r.dir_z) * 8;
        return r;
    endfunction

    task automatic test_directed();
        rsi_pkg::ray_t r;
        set_sphere(32'h0005_0000, 0, 0, 32'h0008_0000, 32'h0001_0000, 0, 32'h0001_0000);
        r = '0;
        r.dir_x = 18'sd65536;
        send_ray(r);                               // hits: both ahead
        r.origin_x = 32'h0005_0000;
        send_ray(r);                               // origin inside sphere
        r.origin_x = 32'h000A_0000;
        send_ray(r);                               // sphere behind
        r.origin_x = 0; r.origin_y = 32'h0005_0000;
        send_ray(r);                               // miss
        r.origin_y = 32'h0001_0000;
        send_ray(r);                               // tangent: delta zero
        r.origin_y = 0;
        for (int k = 14; k <= 31; k += (k < 17 ? 1 : 14))
        begin
            r.hit_index = 5'(k);
            send_ray(r);                           // at and past the limit
        end
        r.hit_index = 0;
        r.blur_on = 1'b1;
        r.shutter_time = 17'h1FFFF;                // above one saturates
        send_ray(r);
        r.shutter_time = rsi_pkg::TIME_ONE;
        send_ray(r);
        r.shutter_time = 17'd32768;
        send_ray(r);
        r.dir_x = -18'sd65536;
        send_ray(r);
        r.dir_x = 18'sh1FFFF; r.dir_y = 18'sh20000; r.dir_z = 18'sh1FFFF;
        send_ray(r);                               // non-unit extremes
        r = '1;
        send_ray(r);
        r = '0;
        r.origin_x = 32'h8000_0000; r.origin_y = 32'h7FFF_FFFF; r.origin_z = 32'h8000_0000;
        r.dir_x = 18'sd65536;
        send_ray(r);
        idle_input();
        drain();
        // huge radius: far distance saturates
        set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        r.blur_on = 1'b1; r.shutter_time = 17'd40000;
        send_ray(r);
        r.origin_x = 32'h8000_0000; r.blur_on = 1'b0;
        send_ray(r);
        idle_input();
        drain();
    endtask

    task automatic test_random(input int n);
        for (int k = 0; k < n; k++)
            send_ray(($urandom_range(0, 3) != 0) ? aimed_ray() : rand_ray($urandom_range(0, 1)));
        idle_input();
        drain();
    endtask

    // hold off results long enough to fill every stage while rays keep coming
    task automatic test_backpressure();
        hold_cycles = 0;
        hold_off    = 1'b1;
        fork
            begin
                while (hold_cycles < 3 * LATENCY)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int k = 0; k < 80; k++)
                    send_ray(aimed_ray(), 1'b1);
            end
        join
        idle_input();
        drain();
    endtask

    task automatic test_radius_zero();
        set_sphere(0, 32'hFFFF_0000, 32'h0003_0000, 0, 32'h0001_0000, 32'hFFFD_0000, 0);
        test_random(40);
    endtask

    initial
    begin
        cycle       = 0;
        mismatches  = 0;
        err_flag    = 1'b0;
        hold_off    = 1'b0;
        hold_cycles = 0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = rsi_pkg::CFG_CENTER_X;
        cfg_data    = '0;
        rays.valid  = 1'b0;
        rays.origin_x = '0; rays.origin_y = '0; rays.origin_z = '0;
        rays.dir_x  = '0; rays.dir_y = '0; rays.dir_z = '0;
        rays.shutter_time = '0; rays.blur_on = 1'b0; rays.hit_index = '0;
        for (int i = 0; i < 3; i++)
        begin
            sph_c0[i] = '0;
            sph_c1[i] = '0;
        end
        sph_r = 31'd65536;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_random(30);                           // reset register values
        test_directed();
        set_sphere(32'h0010_0000, 32'hFFF0_0000, 32'h0002_8000,
                   32'hFFE0_0000, 32'h0020_0000, 32'h0000_4000, 32'h0004_0000);
        test_random(300);
        test_backpressure();
        test_radius_zero();
        set_sphere($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   32'($urandom_range(0, 32'h7FFF_FFFF)));
        test_random(150);
        set_sphere(32'hFFFF_8000, 32'h0000_C000, 32'hFFFE_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0020_0000);
        test_random(250);

        if (!err_flag && hit_queue.size() == 0)
            $display("ray_sphere_intersect_core: match");
        else
            $display("ray_sphere_intersect_core: mismatch");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/rsi_pkg.sv
sv/rsi_ray_if.sv
sv/rsi_hit_if.sv
sv/rsi_geom.sv
sv/rsi_sqrt.sv
sv/rsi_out.sv
sv/ray_sphere_intersect_core.sv
test/ray_sphere_intersect_core_tb.sv
